>>> rtl/core/unicycle_pose_integrator_core_assert.svh
// Assertion macros for the pose integrator checker.
// Both expect clk and rst_n in scope.
`ifndef UNICYCLE_POSE_INTEGRATOR_CORE_ASSERT_SVH
`define UNICYCLE_POSE_INTEGRATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define UPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/upi_pkg.sv
`default_nettype none
package upi_pkg;

  localparam int POS_W      = 32;
  localparam int HEAD_W     = 23;
  localparam int HACC_W     = 25;
  localparam int SPD_W      = 16;
  localparam int TRN_W      = 16;
  localparam int DT_W       = 16;
  localparam int TRIG_W     = 32;
  localparam int ZW         = 32;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DPOS_W     = 26;
  localparam int DHEAD_W    = 24;
  localparam int CNT_W      = 5;
  localparam int MAX_STEPS  = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 120;

  localparam logic signed [HACC_W-1:0] PI_Q      = 25'sd3294199;
  localparam logic signed [HACC_W-1:0] HALF_PI_Q = 25'sd1647099;
  localparam logic signed [HACC_W-1:0] TWO_PI_Q  = 25'sd6588398;
  localparam logic signed [TRIG_W-1:0] CORDIC_K  = 32'sd652032875;

  localparam logic [DT_W-1:0]   STEP_TIME_RST  = 16'd3277;
  localparam logic [HEAD_W-1:0] START_HEAD_RST = 23'd1647099;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_X    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD = 4'd3;

  typedef struct packed {
    logic                     start;
    logic signed [HACC_W-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;
  } cordic_rsp_t;

  // atan(2^-i) in Q.28
  function automatic logic signed [ZW-1:0] atan_q28(input logic [CNT_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 32'sd210828714;
      5'd1:    v = 32'sd124459457;
      5'd2:    v = 32'sd65760960;
      5'd3:    v = 32'sd33381289;
      5'd4:    v = 32'sd16755422;
      5'd5:    v = 32'sd8385879;
      5'd6:    v = 32'sd4193963;
      5'd7:    v = 32'sd2097109;
      5'd8:    v = 32'sd1048571;
      5'd9:    v = 32'sd524287;
      5'd10:   v = 32'sd262144;
      5'd11:   v = 32'sd131072;
      5'd12:   v = 32'sd65536;
      5'd13:   v = 32'sd32768;
      5'd14:   v = 32'sd16384;
      5'd15:   v = 32'sd8192;
      5'd16:   v = 32'sd4096;
      5'd17:   v = 32'sd2048;
      5'd18:   v = 32'sd1024;
      5'd19:   v = 32'sd512;
      5'd20:   v = 32'sd256;
      5'd21:   v = 32'sd128;
      5'd22:   v = 32'sd64;
      5'd23:   v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q7.24 x Q1.30 -> Q9.16, round half up
  function automatic logic signed [DPOS_W-1:0] round_pos(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (64'sd1 <<< 37);
    return t[PROD_W-1:38];
  endfunction

  // Q3.28 -> Q3.20, round half up
  function automatic logic signed [DHEAD_W-1:0] round_head(input logic signed [MUL_W-1:0] p);
    logic signed [MUL_W-1:0] t;
    t = p + 32'sd128;
    return t[MUL_W-1:8];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
                                                      input logic signed [DPOS_W-1:0] d);
    logic signed [POS_W:0] s;
    logic signed [POS_W-1:0] r;
    s = {a[POS_W-1], a} + {{(POS_W+1-DPOS_W){d[DPOS_W-1]}}, d};
    if (s[POS_W] != s[POS_W-1]) begin
      r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/unicycle_pose_integrator_core.sv
`default_nettype none
// Euler dead-reckoning pose integrator. Each input beat is one time step:
// x and y advance by speed*cos/sin(heading)*step_time using the heading from
// before the step, then the heading advances by turn_rate*step_time and wraps
// into [-pi, pi). Positions saturate. The first beat after reset loads the
// pose from the start registers; later start writes are ignored until reset.
// Each beat runs the iterative CORDIC, which does one rotation per clock,
// and passes four times through a single shared 32x32 multiplier (speed
// times step_time alongside the CORDIC, then the x, y and heading products),
// followed by up to three heading wrap steps. in_tready is high only when
// the sequencer is idle; one finished result may wait in the output register
// while the next beat is taken. cfg_ready is always high.
module unicycle_pose_integrator_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [15:0] linear_speed, [31:16] turn_rate
  input  wire logic [upi_pkg::IN_W-1:0]         in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [31:0] pose_x, [63:32] pose_y, [86:64] pose_heading,
  // [102:87] speed_echo, [118:103] turn_echo, [119] zero
  output logic [upi_pkg::OUT_W-1:0]             out_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [upi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [upi_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_WRAP   = 4'd2;
  localparam logic [3:0] S_CSTART = 4'd3;
  localparam logic [3:0] S_CWAIT  = 4'd4;
  localparam logic [3:0] S_MX     = 4'd5;
  localparam logic [3:0] S_MY     = 4'd6;
  localparam logic [3:0] S_MH     = 4'd7;
  localparam logic [3:0] S_HADD   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_r, state_nxt;

  logic [upi_pkg::DT_W-1:0]           step_time_r;
  logic [upi_pkg::POS_W-1:0]          start_x_r, start_y_r;
  logic [upi_pkg::HEAD_W-1:0]         start_head_r;
  logic signed [upi_pkg::POS_W-1:0]   cur_x_r, cur_y_r;
  logic signed [upi_pkg::HACC_W-1:0]  cur_h_r;
  logic                               loaded_r, phase_r;
  logic [upi_pkg::SPD_W-1:0]          spd_r;
  logic [upi_pkg::TRN_W-1:0]          trn_r;
  logic signed [upi_pkg::MUL_W-1:0]   vdt_r;
  logic                               out_valid_r;
  logic [upi_pkg::OUT_W-1:0]          out_data_r;

  logic signed [upi_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [upi_pkg::PROD_W-1:0]  prod;
  logic signed [upi_pkg::DHEAD_W-1:0] dhead;
  upi_pkg::cordic_req_t               c_req;
  upi_pkg::cordic_rsp_t               c_rsp;

  logic in_fire, h_hi, h_lo, out_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign h_hi      = (cur_h_r >= upi_pkg::PI_Q);
  assign h_lo      = (cur_h_r < -upi_pkg::PI_Q);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign dhead     = upi_pkg::round_head(prod[upi_pkg::MUL_W-1:0]);

  assign c_req.start = (state_r == S_CSTART);
  assign c_req.angle = cur_h_r;

  upi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (c_req),
    .rsp   (c_rsp)
  );

  always_comb begin
    case (state_r)
      S_MX: begin
        mul_a = vdt_r;
        mul_b = c_rsp.cos_val;
      end
      S_MY: begin
        mul_a = vdt_r;
        mul_b = c_rsp.sin_val;
      end
      S_MH: begin
        mul_a = {{(upi_pkg::MUL_W-upi_pkg::TRN_W){trn_r[upi_pkg::TRN_W-1]}}, trn_r};
        mul_b = {{(upi_pkg::MUL_W-upi_pkg::DT_W){1'b0}}, step_time_r};
      end
      default: begin
        mul_a = {{(upi_pkg::MUL_W-upi_pkg::SPD_W){spd_r[upi_pkg::SPD_W-1]}}, spd_r};
        mul_b = {{(upi_pkg::MUL_W-upi_pkg::DT_W){1'b0}}, step_time_r};
      end
    endcase
  end

  upi_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_fire) state_nxt = loaded_r ? S_CSTART : S_LOAD;
      S_LOAD:   state_nxt = S_WRAP;
      S_WRAP:   if (!h_hi && !h_lo) state_nxt = phase_r ? S_OUT : S_CSTART;
      S_CSTART: state_nxt = S_CWAIT;
      S_CWAIT:  if (c_rsp.done) state_nxt = S_MX;
      S_MX:     state_nxt = S_MY;
      S_MY:     state_nxt = S_MH;
      S_MH:     state_nxt = S_HADD;
      S_HADD:   state_nxt = S_WRAP;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      loaded_r     <= 1'b0;
      phase_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      step_time_r  <= upi_pkg::STEP_TIME_RST;
      start_x_r    <= '0;
      start_y_r    <= '0;
      start_head_r <= upi_pkg::START_HEAD_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          upi_pkg::REG_STEP_TIME:  step_time_r  <= cfg_data[upi_pkg::DT_W-1:0];
          upi_pkg::REG_START_X:    start_x_r    <= cfg_data[upi_pkg::POS_W-1:0];
          upi_pkg::REG_START_Y:    start_y_r    <= cfg_data[upi_pkg::POS_W-1:0];
          upi_pkg::REG_START_HEAD: start_head_r <= cfg_data[upi_pkg::HEAD_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_LOAD) begin
        loaded_r <= 1'b1;
        phase_r  <= 1'b0;
      end
      if (state_r == S_HADD) begin
        phase_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      spd_r <= in_tdata[upi_pkg::SPD_W-1:0];
      trn_r <= in_tdata[upi_pkg::IN_W-1:upi_pkg::SPD_W];
    end
    case (state_r)
      S_LOAD: begin
        cur_x_r <= start_x_r;
        cur_y_r <= start_y_r;
        cur_h_r <= {{(upi_pkg::HACC_W-upi_pkg::HEAD_W){start_head_r[upi_pkg::HEAD_W-1]}},
                    start_head_r};
      end
      S_WRAP: begin
        if (h_hi) begin
          cur_h_r <= cur_h_r - upi_pkg::TWO_PI_Q;
        end else if (h_lo) begin
          cur_h_r <= cur_h_r + upi_pkg::TWO_PI_Q;
        end
      end
      S_CWAIT: vdt_r   <= prod[upi_pkg::MUL_W-1:0];
      S_MY:    cur_x_r <= upi_pkg::sat_add(cur_x_r, upi_pkg::round_pos(prod));
      S_MH:    cur_y_r <= upi_pkg::sat_add(cur_y_r, upi_pkg::round_pos(prod));
      S_HADD: begin
        cur_h_r <= cur_h_r +
                   $signed({{(upi_pkg::HACC_W-upi_pkg::DHEAD_W){dhead[upi_pkg::DHEAD_W-1]}},
                            dhead});
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= {1'b0, trn_r, spd_r, cur_h_r[upi_pkg::HEAD_W-1:0], cur_y_r, cur_x_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

>>> rtl/core/upi_mul.sv
`default_nettype none
module upi_mul (
  input  wire logic                               clk,
  input  wire logic signed [upi_pkg::MUL_W-1:0]   op_a,
  input  wire logic signed [upi_pkg::MUL_W-1:0]   op_b,
  output logic signed      [upi_pkg::PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule
`default_nettype wire

>>> rtl/core/upi_cordic.sv
`default_nettype none
module upi_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire upi_pkg::cordic_req_t req,
  output upi_pkg::cordic_rsp_t      rsp
);

  localparam int NSTEP = (STEPS < upi_pkg::MAX_STEPS) ? STEPS : upi_pkg::MAX_STEPS;
  localparam logic [upi_pkg::CNT_W-1:0] LAST = upi_pkg::CNT_W'(NSTEP - 1);

  logic signed [upi_pkg::TRIG_W-1:0] x_r, y_r;
  logic signed [upi_pkg::ZW-1:0]     z_r;
  logic [upi_pkg::CNT_W-1:0]         i_r;
  logic                              busy_r, done_r, neg_r;

  logic signed [upi_pkg::HACC_W-1:0] fold_h;
  logic                              fold_neg;
  logic signed [upi_pkg::ZW-1:0]     z_init;
  logic signed [upi_pkg::TRIG_W-1:0] xs, ys;
  logic signed [upi_pkg::ZW-1:0]     atan_i;

  // bring angle into [-pi/2, pi/2], flip result signs
  always_comb begin
    fold_h   = req.angle;
    fold_neg = 1'b0;
    if (req.angle > upi_pkg::HALF_PI_Q) begin
      fold_h   = req.angle - upi_pkg::PI_Q;
      fold_neg = 1'b1;
    end else if (req.angle < -upi_pkg::HALF_PI_Q) begin
      fold_h   = req.angle + upi_pkg::PI_Q;
      fold_neg = 1'b1;
    end
  end

  assign z_init = {fold_h[upi_pkg::HEAD_W-1], fold_h[upi_pkg::HEAD_W-1:0], 8'b0};
  assign xs     = x_r >>> i_r;
  assign ys     = y_r >>> i_r;
  assign atan_i = upi_pkg::atan_q28(i_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      i_r    <= '0;
    end else if (busy_r) begin
      if (i_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        i_r <= i_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= upi_pkg::CORDIC_K;
      y_r   <= '0;
      z_r   <= z_init;
      neg_r <= fold_neg;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_i;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_i;
      end
    end
  end

  assign rsp.done    = done_r;
  assign rsp.cos_val = neg_r ? -x_r : x_r;
  assign rsp.sin_val = neg_r ? -y_r : y_r;

endmodule
`default_nettype wire

>>> rtl/core/upi_checker.sv
`default_nettype none
`include "unicycle_pose_integrator_core_assert.svh"
module upi_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [upi_pkg::OUT_W-1:0]   out_tdata
);

  logic signed [upi_pkg::HACC_W-1:0] hd;
  assign hd = {{(upi_pkg::HACC_W-upi_pkg::HEAD_W){out_tdata[86]}}, out_tdata[86:64]};

  `UPI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `UPI_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready right after accept")
  `UPI_ASSERT_NEXT(a_no_instant_result, in_tvalid && in_tready && !out_tvalid, !out_tvalid, "result without work")
  `UPI_ASSERT_NOW(a_heading_range, out_tvalid, (hd >= -upi_pkg::PI_Q) && (hd < upi_pkg::PI_Q) && !out_tdata[119], "heading out of range")

endmodule

bind unicycle_pose_integrator_core upi_checker u_upi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

>>> bench/unicycle_pose_integrator_core_tb.sv
`timescale 1ns / 100ps

module unicycle_pose_integrator_core_tb;

  localparam int STEPS = 16;
  localparam int PHASES = 12;
  localparam int PHASE_BEATS = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT = 1000000;
  localparam logic [upi_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = upi_pkg::REG_START_HEAD + 4'd1;
  localparam logic [upi_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 4'hF;
  localparam longint ATAN_TAB [24] = '{
    210828714, 124459457, 65760960, 33381289, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32
  };

  typedef struct packed {
    logic signed [upi_pkg::POS_W-1:0]  x;
    logic signed [upi_pkg::POS_W-1:0]  y;
    logic signed [upi_pkg::HEAD_W-1:0] heading;
    logic [upi_pkg::SPD_W-1:0]         speed;
    logic [upi_pkg::TRN_W-1:0]         turn;
  } pose_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_BEAT, ROW_BEAT_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [upi_pkg::CFG_IDX_W-1:0]   idx;
    logic [upi_pkg::CFG_DATA_W-1:0]  data;
    logic [upi_pkg::SPD_W-1:0]       spd;
    logic [upi_pkg::TRN_W-1:0]       trn;
    pose_t                           want;
  } row_t;

  localparam pose_t NO_POSE = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [upi_pkg::IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [upi_pkg::OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [upi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [upi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state and register mirror
  logic [upi_pkg::DT_W-1:0] dt_cfg;
  logic [upi_pkg::POS_W-1:0] sx_cfg, sy_cfg;
  logic [upi_pkg::HEAD_W-1:0] sh_cfg;
  longint pos_x, pos_y, head;
  bit pose_valid;

  pose_t pose_q[$];
  pose_t want_pose;
  row_t plan[$];

  bit hold_req = 1'b0;
  bit calm = 1'b0;
  int errors = 0;
  int n_beats = 0;
  int n_checked = 0;
  int n_sat = 0;
  int n_dt_writes = 0;
  int n_holds = 0;
  int cycles = 0;

  unicycle_pose_integrator_core #(
    .CORDIC_STEPS(STEPS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint wrap_angle(input longint h);
    longint pi;
    pi = longint'(upi_pkg::PI_Q);
    while (h >= pi) h = h - 2 * pi;
    while (h < -pi) h = h + 2 * pi;
    return h;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sh7FFF_FFFF) begin
      n_sat++;
      return 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      n_sat++;
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  function automatic void unit_vector(input longint ang, output longint c, output longint s);
    longint vx, vy, vz, nx, half, pi;
    bit flip;
    int i;
    half = longint'(upi_pkg::HALF_PI_Q);
    pi = longint'(upi_pkg::PI_Q);
    flip = 1'b0;
    if (ang > half) begin
      ang = ang - pi;
      flip = 1'b1;
    end else if (ang < -half) begin
      ang = ang + pi;
      flip = 1'b1;
    end
    vx = longint'(upi_pkg::CORDIC_K);
    vy = 0;
    vz = ang * 256;
    for (i = 0; i < STEPS && i < 24; i++) begin
      if (vz >= 0) begin
        nx = vx - (vy >>> i);
        vy = vy + (vx >>> i);
        vz = vz - ATAN_TAB[i];
      end else begin
        nx = vx + (vy >>> i);
        vy = vy - (vx >>> i);
        vz = vz + ATAN_TAB[i];
      end
      vx = nx;
    end
    c = flip ? -vx : vx;
    s = flip ? -vy : vy;
  endfunction

  function automatic pose_t integrate_step(input logic [upi_pkg::SPD_W-1:0] spd,
                                           input logic [upi_pkg::TRN_W-1:0] trn);
    longint vdt, dt, c, s;
    pose_t r;
    if (!pose_valid) begin
      pos_x = longint'($signed(sx_cfg));
      pos_y = longint'($signed(sy_cfg));
      head = wrap_angle(longint'($signed(sh_cfg)));
      pose_valid = 1'b1;
    end
    dt = longint'(dt_cfg);
    vdt = longint'($signed(spd)) * dt;
    unit_vector(head, c, s);
    pos_x = clamp32(pos_x + ((vdt * c + (longint'(1) <<< 37)) >>> 38));
    pos_y = clamp32(pos_y + ((vdt * s + (longint'(1) <<< 37)) >>> 38));
    head = wrap_angle(head + ((longint'($signed(trn)) * dt + 128) >>> 8));
    r.x = pos_x[upi_pkg::POS_W-1:0];
    r.y = pos_y[upi_pkg::POS_W-1:0];
    r.heading = head[upi_pkg::HEAD_W-1:0];
    r.speed = spd;
    r.turn = trn;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timed out after %0d cycles, %0d poses still pending", cycles, pose_q.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pose_q.size() == 0) begin
        flag_error($sformatf("unexpected pose beat %h", out_tdata));
      end else begin
        want_pose = pose_q.pop_front();
        check_field("pose_x", out_tdata[31:0], want_pose.x);
        check_field("pose_y", out_tdata[63:32], want_pose.y);
        check_field("pose_heading", {9'd0, out_tdata[86:64]}, {9'd0, want_pose.heading});
        check_field("speed_echo", {16'd0, out_tdata[102:87]}, {16'd0, want_pose.speed});
        check_field("turn_echo", {16'd0, out_tdata[118:103]}, {16'd0, want_pose.turn});
        n_checked++;
      end
    end
  end

  initial begin : sink
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        n_holds++;
      end else if (calm) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 9);
        out_tready <= ($urandom_range(0, 2) != 0);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [upi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [upi_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      upi_pkg::REG_STEP_TIME: begin
        dt_cfg = data[upi_pkg::DT_W-1:0];
        n_dt_writes++;
      end
      upi_pkg::REG_START_X: sx_cfg = data;
      upi_pkg::REG_START_Y: sy_cfg = data;
      upi_pkg::REG_START_HEAD: sh_cfg = data[upi_pkg::HEAD_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_beat(input logic [upi_pkg::SPD_W-1:0] spd,
                           input logic [upi_pkg::TRN_W-1:0] trn,
                           input bit typed, input pose_t typed_pose);
    pose_t p;
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {trn, spd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = integrate_step(spd, trn);
    pose_q.push_back(typed ? typed_pose : p);
    n_beats++;
  endtask

  function automatic row_t cfg_row(input logic [upi_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [upi_pkg::CFG_DATA_W-1:0] data);
    return '{ROW_CFG, idx, data, 16'h0, 16'h0, NO_POSE};
  endfunction

  function automatic row_t beat_row(input logic [upi_pkg::SPD_W-1:0] spd,
                                    input logic [upi_pkg::TRN_W-1:0] trn);
    return '{ROW_BEAT, 4'h0, 32'h0, spd, trn, NO_POSE};
  endfunction

  function automatic logic [15:0] pick_cmd();
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0, 1, 2: return 16'($urandom);
      3, 4: begin
        v = 16'($urandom_range(0, 1023));
        return ($urandom_range(0, 1) != 0) ? -v : v;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'hFFFF;
          3: return 16'h0001;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [upi_pkg::DT_W-1:0] pick_dt(input int ph);
    if (ph == 0) return 16'hFFFF;
    if (ph == 1) return 16'd1;
    if (ph == 5) return 16'd0;
    case ($urandom_range(0, 3))
      0: return upi_pkg::STEP_TIME_RST;
      1: return 16'($urandom_range(1, 65535));
      2: return 16'($urandom_range(1, 64));
      default: return 16'hFFFF;
    endcase
  endfunction

  initial begin : stim
    int ph, k;
    dt_cfg = upi_pkg::STEP_TIME_RST;
    sx_cfg = '0;
    sy_cfg = '0;
    sh_cfg = upi_pkg::START_HEAD_RST;
    pose_valid = 1'b0;
    pos_x = 0;
    pos_y = 0;
    head = 0;

    plan.push_back(cfg_row(upi_pkg::REG_STEP_TIME, 32'h0000_FFFF));
    plan.push_back(cfg_row(upi_pkg::REG_START_X, 32'h7FFF_0000));
    plan.push_back(cfg_row(upi_pkg::REG_START_Y, 32'h8000_0000));
    plan.push_back(cfg_row(upi_pkg::REG_START_HEAD, 32'h003F_FFFF));
    plan.push_back(cfg_row(REG_UNUSED_HI, 32'h0000_0000));
    // start pose loaded, heading wrapped by one turn
    plan.push_back('{ROW_BEAT_TYPED, 4'h0, 32'h0, 16'h0000, 16'h0000,
                     '{32'h7FFF_0000, 32'h8000_0000, -23'sd2394095, 16'h0000, 16'h0000}});
    plan.push_back(beat_row(16'h7FFF, 16'h0000));
    plan.push_back(beat_row(16'h8000, 16'h0000));
    plan.push_back(beat_row(16'h0000, 16'h7FFF));
    plan.push_back(beat_row(16'h7FFF, 16'h8000));
    plan.push_back(beat_row(16'h8000, 16'h7FFF));
    plan.push_back(beat_row(16'h5555, 16'hAAAA));
    plan.push_back(beat_row(16'hAAAA, 16'h5555));
    plan.push_back(beat_row(16'h0001, 16'h0001));
    plan.push_back(beat_row(16'hFFFF, 16'hFFFF));
    plan.push_back(cfg_row(upi_pkg::REG_STEP_TIME, 32'h0000_0000));
    plan.push_back(beat_row(16'h7FFF, 16'h7FFF));
    plan.push_back(beat_row(16'h8000, 16'h8000));
    // start registers no longer matter once the pose is loaded
    plan.push_back(cfg_row(upi_pkg::REG_START_X, 32'h1234_5678));
    plan.push_back(cfg_row(upi_pkg::REG_START_Y, 32'h8765_4321));
    plan.push_back(cfg_row(upi_pkg::REG_START_HEAD, 32'h0040_0000));
    plan.push_back(cfg_row(upi_pkg::REG_STEP_TIME, 32'h0000_0001));
    plan.push_back(beat_row(16'h7FFF, 16'h7FFF));
    plan.push_back(beat_row(16'h8000, 16'h8000));
    plan.push_back(cfg_row(upi_pkg::REG_STEP_TIME, {16'h0, upi_pkg::STEP_TIME_RST}));
    plan.push_back(beat_row(16'h3200, 16'h1922));
    plan.push_back(beat_row(16'h3200, 16'h1922));
    plan.push_back(beat_row(16'hCE00, 16'hE6DE));
    plan.push_back(beat_row(16'h0100, 16'h7FFF));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      case (plan[r].kind)
        ROW_CFG: begin
          drain_results();
          write_reg(plan[r].idx, plan[r].data);
        end
        ROW_BEAT: send_beat(plan[r].spd, plan[r].trn, 1'b0, NO_POSE);
        default: send_beat(plan[r].spd, plan[r].trn, 1'b1, plan[r].want);
      endcase
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      if (ph == PHASES - 1) calm = 1'b1;
      write_reg(upi_pkg::REG_STEP_TIME, {16'h0, pick_dt(ph)});
      write_reg(upi_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
      write_reg(upi_pkg::CFG_IDX_W'($urandom_range(upi_pkg::REG_START_X,
                                                   upi_pkg::REG_START_HEAD)), $urandom);
      for (k = 0; k < PHASE_BEATS; k++) begin
        if (ph == 2 && k == 40) hold_req = 1'b1;
        send_beat(pick_cmd(), pick_cmd(), 1'b0, NO_POSE);
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    $display("Integrated %0d steps under %0d step-time settings, %0d poses compared",
             n_beats, n_dt_writes, n_checked);
    $display("Position clamps %0d, long sink stalls %0d, mismatches %0d",
             n_sat, n_holds, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
